[rtl/core/uqps_pkg.sv]
// Shared types and constants for the URL query parameter splitter.
// Holds the result item layout, kind codes, register indexes, reset values, parser characters and queue depth.
// No dependencies.
package uqps_pkg;

	// Kind codes carried with every result.
	typedef enum logic [1:0] {
		KIND_NAME      = 2'd0,
		KIND_VALUE     = 2'd1,
		KIND_PARAM_END = 2'd2,
		KIND_QUERY_END = 2'd3
	} kind_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  param_index;
		logic [7:0]  param_total;
		logic        run_last;
	} item_t;

	// Results of one input byte, compacted into the low slots.
	typedef struct packed {
		logic [1:0]      count;
		item_t [2:0]     items;
	} step_res_t;

	// Register indexes, taken from address bit 2 of the configuration port.
	localparam logic REG_MAX_PARAMS    = 1'b0;
	localparam logic REG_DECODE_ENABLE = 1'b1;

	localparam logic [7:0] MAX_PARAMS_RST    = 8'd10;
	localparam logic       DECODE_ENABLE_RST = 1'b0;

	// Characters the parser looks for.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	// Result queue size: holds the results of one byte plus one waiting result.
	localparam int unsigned QUEUE_DEPTH = 4;

endpackage

[rtl/core/uqps_parse.sv]
// Parser state and per-byte result logic of the URL query parameter splitter.
// Produces up to three compacted results for one byte and updates the parse state.
// Depends on uqps_pkg.
module uqps_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           character,
	input  logic [7:0]           max_params,
	input  logic                 decode_enable,
	output uqps_pkg::step_res_t  res
);

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	esc_t        esc_q, esc_n;
	logic [3:0]  hi_nib_q, hi_nib_n;
	logic        field_q, field_n;
	logic [7:0]  done_q, done_n;
	logic        nonempty_q, nonempty_n;

	logic        active;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic        consumed;
	logic        a_v, b_v, c_v;
	uqps_pkg::item_t a_item, b_item, c_item;
	uqps_pkg::kind_t data_kind;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= uqps_pkg::CH_0 && c <= uqps_pkg::CH_9) begin
				t = c - uqps_pkg::CH_0;
				return {1'b1, t[3:0]};
			end else if (c >= uqps_pkg::CH_UA && c <= uqps_pkg::CH_UF) begin
				t = c - uqps_pkg::CH_UA + 8'd10;
				return {1'b1, t[3:0]};
			end else if (c >= uqps_pkg::CH_LA && c <= uqps_pkg::CH_LF) begin
				t = c - uqps_pkg::CH_LA + 8'd10;
				return {1'b1, t[3:0]};
			end
			return 5'd0;
		end
	endfunction

	assign active    = done_q < max_params;
	assign {hex_ok, hex_val} = hex_decode(character);
	assign data_kind = field_q ? uqps_pkg::KIND_VALUE : uqps_pkg::KIND_NAME;

	always_comb begin
		esc_n      = esc_q;
		hi_nib_n   = hi_nib_q;
		field_n    = field_q;
		done_n     = done_q;
		nonempty_n = nonempty_q;
		consumed   = 1'b0;
		a_v        = 1'b0;
		b_v        = 1'b0;
		c_v        = 1'b0;
		a_item     = '{kind: data_kind, data_byte: 8'd0, param_index: done_q,
			param_total: 8'd0, run_last: 1'b0};
		b_item     = a_item;
		c_item     = '{kind: uqps_pkg::KIND_QUERY_END, data_byte: 8'd0, param_index: 8'd0,
			param_total: 8'd0, run_last: 1'b0};

		// A pending escape sees the byte first; a non-hex byte flushes it.
		if (active && esc_q != ESC_NONE) begin
			if (esc_q == ESC_PCT && hex_ok) begin
				consumed = 1'b1;
				esc_n    = ESC_DIGIT;
				hi_nib_n = hex_val;
			end else begin
				a_v              = 1'b1;
				a_item.data_byte = (esc_q == ESC_DIGIT) ? {hi_nib_q, hex_ok ? hex_val : 4'h0}
					: 8'd0;
				consumed         = (esc_q == ESC_DIGIT) && hex_ok;
				esc_n            = ESC_NONE;
				hi_nib_n         = 4'd0;
			end
		end

		if (!consumed) begin
			if (character == uqps_pkg::CH_NUL) begin
				if (active && nonempty_q) begin
					b_v         = 1'b1;
					b_item.kind = uqps_pkg::KIND_PARAM_END;
				end
				c_v                = 1'b1;
				c_item.param_total = (active && nonempty_q) ? done_q + 8'd1 : done_q;
				done_n             = 8'd0;
				field_n            = 1'b0;
				nonempty_n         = 1'b0;
				esc_n              = ESC_NONE;
				hi_nib_n           = 4'd0;
			end else if (!active) begin
				// Limit reached: the byte is dropped.
			end else if (character == uqps_pkg::CH_AMP) begin
				b_v         = 1'b1;
				b_item.kind = uqps_pkg::KIND_PARAM_END;
				done_n      = done_q + 8'd1;
				field_n     = 1'b0;
				nonempty_n  = 1'b0;
				esc_n       = ESC_NONE;
				hi_nib_n    = 4'd0;
			end else begin
				nonempty_n = 1'b1;
				priority if (!field_q && character == uqps_pkg::CH_EQ) begin
					field_n = 1'b1;
				end else if (decode_enable && character == uqps_pkg::CH_PLUS) begin
					b_v              = 1'b1;
					b_item.data_byte = uqps_pkg::CH_SPACE;
				end else if (decode_enable && character == uqps_pkg::CH_PCT) begin
					esc_n    = ESC_PCT;
					hi_nib_n = 4'd0;
				end else begin
					b_v              = 1'b1;
					b_item.data_byte = character;
				end
			end
		end
	end

	// Compact the three slots in order and mark the last one.
	always_comb begin
		res.count    = 2'(a_v) + 2'(b_v) + 2'(c_v);
		res.items[0] = a_v ? a_item : (b_v ? b_item : c_item);
		res.items[1] = (a_v && b_v) ? b_item : c_item;
		res.items[2] = c_item;
		unique case (res.count)
			2'd1:    res.items[0].run_last = 1'b1;
			2'd2:    res.items[1].run_last = 1'b1;
			2'd3:    res.items[2].run_last = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q      <= ESC_NONE;
			hi_nib_q   <= 4'd0;
			field_q    <= 1'b0;
			done_q     <= 8'd0;
			nonempty_q <= 1'b0;
		end else if (fire) begin
			esc_q      <= esc_n;
			hi_nib_q   <= hi_nib_n;
			field_q    <= field_n;
			done_q     <= done_n;
			nonempty_q <= nonempty_n;
		end
	end

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && character == uqps_pkg::CH_NUL |=> done_q == 8'd0 && !field_q && !nonempty_q)
		else $error("terminator did not clear the parse state");

	a_three_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.count == 2'd3 |-> res.items[1].kind == uqps_pkg::KIND_PARAM_END
			&& res.items[2].kind == uqps_pkg::KIND_QUERY_END)
		else $error("three results out of order");

	a_limit_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !active && character != uqps_pkg::CH_NUL |-> res.count == 2'd0)
		else $error("result produced past the parameter limit");

endmodule

[rtl/core/uqps_outq.sv]
// Result queue of the URL query parameter splitter.
// Takes up to three results in one cycle and hands out one per cycle while out_ready is high.
// Depends on uqps_pkg.
module uqps_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  uqps_pkg::step_res_t  res,
	input  logic                 out_ready,
	output logic                 out_valid,
	output uqps_pkg::item_t      out_item,
	output logic                 room
);

	localparam int unsigned PTR_W = $clog2(uqps_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(uqps_pkg::QUEUE_DEPTH + 1);

	uqps_pkg::item_t     mem_q [uqps_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    head_q, tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    push_n;
	logic                pop;

	assign out_valid = count_q != '0;
	assign out_item  = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign push_n    = push ? CNT_W'(res.count) : '0;
	// Room for a full set of three results after this cycle's pop.
	assign room      = (count_q - CNT_W'(pop)) <= CNT_W'(uqps_pkg::QUEUE_DEPTH - 3);

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (push && CNT_W'(j) < push_n) begin
				mem_q[tail_q + PTR_W'(j)] <= res.items[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + PTR_W'(1);
			end
			tail_q  <= tail_q + PTR_W'(push_n);
			count_q <= count_q + push_n - CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(uqps_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == '0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("queue count wrong after pop");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		!pop && push |=> count_q == $past(count_q) + $past(push_n))
		else $error("queue count wrong after push");

endmodule

[rtl/core/url_query_param_splitter_core.sv]
// URL query parameter splitter: configuration registers, input byte register, parse logic, result queue.
// An accepted byte is held in the input byte register, then written to the result queue.
// Throughput: one byte per cycle until results pile up; the queue drains one result
// per cycle while ready, and input stalls while more than one would stay after the pop.
// Reset (arst_n, asynchronous, active low) clears parse state and queue and reloads
// the configuration registers with their reset values.
module url_query_param_splitter_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input byte stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] param_index, [23:16] param_total
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,   // run_last
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                 limit_zero;
	logic [7:0]           max_params_r_q;
	logic                 decode_enable_q;
	logic                 cfg_write;

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 fire;
	logic                 room;

	uqps_pkg::step_res_t  res;
	uqps_pkg::item_t      out_item;

	// Configuration registers. Register index is address bit 2; the low
	// address bits are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_params_r_q  <= uqps_pkg::MAX_PARAMS_RST;
			decode_enable_q <= uqps_pkg::DECODE_ENABLE_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				uqps_pkg::REG_MAX_PARAMS:    max_params_r_q  <= pwdata[7:0];
				uqps_pkg::REG_DECODE_ENABLE: decode_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Reads return the addressed register, zero extended.
	always_comb begin
		unique case (paddr[2])
			uqps_pkg::REG_MAX_PARAMS:    prdata = {24'd0, max_params_r_q};
			uqps_pkg::REG_DECODE_ENABLE: prdata = {31'd0, decode_enable_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// Single byte input register. It is parsed as soon as the result queue can
	// take a full set of three results, so a new request is accepted in the same
	// cycle the held byte leaves.
	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
		end
	end

	// Parse logic: state update and up to three results per byte.
	uqps_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.character     (char_s1),
		.max_params    (max_params_r_q),
		.decode_enable (decode_enable_q),
		.res           (res)
	);

	// Result queue, drained one result per cycle while m_axis_tready is high.
	uqps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_item  (out_item),
		.room      (room)
	);

	assign m_axis_tdata = {out_item.param_total, out_item.param_index, out_item.data_byte};
	assign m_axis_tuser = out_item.kind;
	assign m_axis_tlast = out_item.run_last;

	// With a zero parameter limit only the terminator gives a result.
	assign limit_zero = max_params_r_q == 8'd0;

	a_zero_limit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && limit_zero && char_s1 != uqps_pkg::CH_NUL |-> res.count == 2'd0)
		else $error("results produced with a zero parameter limit");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |-> !s_axis_tready)
		else $error("input taken while the held byte is blocked");

	a_fire_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> valid_s1 == $past(s_axis_tvalid))
		else $error("input register lost a request");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for url_query_param_splitter_core.
// Drives query strings as byte requests and checks every tagged result against an
// in-bench parser model. Depends on uqps_pkg and the core RTL only.
module testbench;

	localparam int          WATCHDOG_LIMIT   = 2000;
	localparam int          DRAIN_CYCLES     = 4;
	localparam int          HOLD_CYCLES      = 60;
	localparam int          PHASE_COUNT      = 6;
	localparam int          CHARS_PER_PHASE  = 38;
	localparam logic [2:0]  ADDR_MAX_PARAMS  = {uqps_pkg::REG_MAX_PARAMS, 2'b00};
	localparam logic [2:0]  ADDR_DECODE      = {uqps_pkg::REG_DECODE_ENABLE, 2'b00};

	// Progress of a percent escape inside the parser model.
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HIGH = 2'd2
	} escape_state_t;

	// One line of the directed table: a register write or one input byte,
	// optionally with its single result spelled out by hand.
	typedef struct {
		bit              is_cfg;
		logic [2:0]      addr;
		logic [31:0]     value;
		logic [7:0]      ch;
		bit              typed;
		uqps_pkg::item_t want;
	} dir_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        s_axis_tvalid  = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata   = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready  = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel           = 1'b0;
	logic        penable        = 1'b0;
	logic        pwrite         = 1'b0;
	logic [2:0]  paddr          = 3'd0;
	logic [31:0] pwdata         = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Register copies and parse state of the model, at their reset values.
	logic [7:0]    cfg_max_params  = uqps_pkg::MAX_PARAMS_RST;
	logic          cfg_decode      = uqps_pkg::DECODE_ENABLE_RST;
	bit            field_is_value  = 1'b0;
	logic [7:0]    params_closed   = 8'd0;
	bit            param_has_bytes = 1'b0;
	escape_state_t escape_state    = ESC_NONE;
	logic [3:0]    escape_hi       = 4'd0;

	uqps_pkg::item_t expected_items[$];
	dir_row_t        dir_rows[$];
	logic [7:0]      query_chars[$];

	int  tx_idle_pct  = 0;
	int  rx_stall_pct = 0;
	bit  rx_hold_req  = 1'b0;
	int  mismatches   = 0;
	int  quiet_cycles = 0;

	url_query_param_splitter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic uqps_pkg::item_t result_of(input uqps_pkg::kind_t k,
			input logic [7:0] d, input logic [7:0] idx, input logic [7:0] total,
			input logic last);
		uqps_pkg::item_t r;
		r.kind        = k;
		r.data_byte   = d;
		r.param_index = idx;
		r.param_total = total;
		r.run_last    = last;
		return r;
	endfunction

	// A name or value byte of the parameter currently being collected.
	function automatic uqps_pkg::item_t field_byte(input logic [7:0] d);
		return result_of(field_is_value ? uqps_pkg::KIND_VALUE : uqps_pkg::KIND_NAME, d,
			params_closed, 8'h00, 1'b0);
	endfunction

	function automatic int hex_digit_value(input logic [7:0] ch);
		if (ch >= uqps_pkg::CH_0 && ch <= uqps_pkg::CH_9)
			return int'(ch - uqps_pkg::CH_0);
		if (ch >= uqps_pkg::CH_UA && ch <= uqps_pkg::CH_UF)
			return int'(ch - uqps_pkg::CH_UA) + 10;
		if (ch >= uqps_pkg::CH_LA && ch <= uqps_pkg::CH_LF)
			return int'(ch - uqps_pkg::CH_LA) + 10;
		return -1;
	endfunction

	function automatic void start_param();
		field_is_value  = 1'b0;
		param_has_bytes = 1'b0;
		escape_state    = ESC_NONE;
		escape_hi       = 4'd0;
	endfunction

	// Advances the model by one accepted byte and queues the results it causes.
	function automatic void parse_char(input logic [7:0] ch);
		uqps_pkg::item_t outs[$];
		int    digit;
		bit    active;
		bit    escape_done;
		active      = params_closed < cfg_max_params;
		digit       = hex_digit_value(ch);
		escape_done = 1'b0;

		// A pending escape sees the byte first. A non-hex byte flushes the
		// partial value and is then parsed as if no escape had been open.
		if (active && escape_state != ESC_NONE) begin
			if (escape_state == ESC_PCT) begin
				if (digit >= 0) begin
					escape_hi    = digit[3:0];
					escape_state = ESC_HIGH;
					return;
				end
				outs.push_back(field_byte(8'h00));
			end else begin
				if (digit >= 0) begin
					outs.push_back(field_byte({escape_hi, digit[3:0]}));
					escape_done = 1'b1;
				end else begin
					outs.push_back(field_byte({escape_hi, 4'h0}));
				end
			end
			escape_state = ESC_NONE;
			escape_hi    = 4'd0;
		end

		if (!escape_done) begin
			if (ch == uqps_pkg::CH_NUL) begin
				// The terminator closes only a parameter that saw any byte.
				if (active && param_has_bytes) begin
					outs.push_back(result_of(uqps_pkg::KIND_PARAM_END, 8'h00, params_closed,
						8'h00, 1'b0));
					params_closed++;
				end
				outs.push_back(result_of(uqps_pkg::KIND_QUERY_END, 8'h00, 8'h00,
					params_closed, 1'b0));
				params_closed = 8'd0;
				start_param();
			end else if (active) begin
				if (ch == uqps_pkg::CH_AMP) begin
					outs.push_back(result_of(uqps_pkg::KIND_PARAM_END, 8'h00, params_closed,
						8'h00, 1'b0));
					params_closed++;
					start_param();
				end else begin
					param_has_bytes = 1'b1;
					if (!field_is_value && ch == uqps_pkg::CH_EQ) begin
						field_is_value = 1'b1;
					end else if (cfg_decode && ch == uqps_pkg::CH_PLUS) begin
						outs.push_back(field_byte(uqps_pkg::CH_SPACE));
					end else if (cfg_decode && ch == uqps_pkg::CH_PCT) begin
						escape_state = ESC_PCT;
						escape_hi    = 4'd0;
					end else begin
						outs.push_back(field_byte(ch));
					end
				end
			end
			// Past the parameter limit every byte but the terminator is dropped.
		end

		if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i]) expected_items.push_back(outs[i]);
	endfunction

	// ------------------------------------------------------------------
	// Random query strings
	// ------------------------------------------------------------------

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return uqps_pkg::CH_0 + 8'(v);
		return (($urandom_range(1) != 0) ? uqps_pkg::CH_UA : uqps_pkg::CH_LA) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] plain_char();
		unique case ($urandom_range(2))
			0: return uqps_pkg::CH_LA + 8'($urandom_range(25));
			1: return uqps_pkg::CH_UA + 8'($urandom_range(25));
			default: return uqps_pkg::CH_0 + 8'($urandom_range(9));
		endcase
	endfunction

	// One piece of a name or value: mostly plain text, with pluses, full and
	// broken escapes, stray equals signs and the odd arbitrary byte.
	function automatic void push_element();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			query_chars.push_back(plain_char());
		end else if (pick < 72) begin
			query_chars.push_back(uqps_pkg::CH_PLUS);
		end else if (pick < 85) begin
			query_chars.push_back(uqps_pkg::CH_PCT);
			query_chars.push_back(hex_char(4'($urandom_range(15))));
			query_chars.push_back(hex_char(4'($urandom_range(15))));
		end else if (pick < 90) begin
			// Broken escape: whatever follows may cut it short.
			query_chars.push_back(uqps_pkg::CH_PCT);
			if ($urandom_range(1)) query_chars.push_back(hex_char(4'($urandom_range(15))));
		end else if (pick < 95) begin
			query_chars.push_back(uqps_pkg::CH_EQ);
		end else begin
			query_chars.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	// Builds one terminated query string in query_chars. Most are well formed;
	// one in ten is a run of arbitrary bytes.
	function automatic void compose_query();
		int params;
		query_chars.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 8)) query_chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			params = $urandom_range(0, 5);
			for (int p = 0; p < params; p++) begin
				repeat ($urandom_range(0, 4)) push_element();
				if ($urandom_range(4) != 0) begin
					query_chars.push_back(uqps_pkg::CH_EQ);
					repeat ($urandom_range(0, 5)) push_element();
				end
				if (p < params - 1 || $urandom_range(3) == 0)
					query_chars.push_back(uqps_pkg::CH_AMP);
			end
		end
		query_chars.push_back(uqps_pkg::CH_NUL);
	endfunction

	// ------------------------------------------------------------------
	// Bus drivers
	// ------------------------------------------------------------------

	// Offers one byte request, idling first at the current rate. Handshakes are
	// sampled at the falling edge, where every signal is settled; the request
	// is taken at the next rising edge.
	task automatic send_char(input logic [7:0] ch, input bit typed,
			input uqps_pkg::item_t want);
		int queued;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(255));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		queued = expected_items.size();
		parse_char(ch);
		// Hand-written rows replace what the model queued with the literal result.
		if (typed) begin
			while (expected_items.size() > queued) void'(expected_items.pop_back());
			expected_items.push_back(want);
		end
	endtask

	// Drops the request line and waits until every expected result is out,
	// then keeps waiting for bytes that produce nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_items.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the
	// rising edge that ends the access with pready high. The bus then idles
	// so that the next write starts with its own setup cycle.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_MAX_PARAMS) cfg_max_params = value[7:0];
		else cfg_decode = value[0];
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------

	function automatic void row_char(input logic [7:0] ch);
		dir_row_t r;
		r = '{default: '0};
		r.ch = ch;
		dir_rows.push_back(r);
	endfunction

	function automatic void row_typed(input logic [7:0] ch, input uqps_pkg::item_t want);
		dir_row_t r;
		r = '{default: '0};
		r.ch    = ch;
		r.typed = 1'b1;
		r.want  = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void row_cfg(input logic [2:0] addr, input logic [31:0] value);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.addr   = addr;
		r.value  = value;
		dir_rows.push_back(r);
	endfunction

	function automatic void build_directed();
		// Reset settings: ten parameters, no decoding.
		row_typed(uqps_pkg::CH_NUL,
			result_of(uqps_pkg::KIND_QUERY_END, 8'h00, 8'h00, 8'h00, 1'b1));
		row_typed("a", result_of(uqps_pkg::KIND_NAME, "a", 8'h00, 8'h00, 1'b1));
		row_char(uqps_pkg::CH_EQ);
		row_typed(8'hFF, result_of(uqps_pkg::KIND_VALUE, 8'hFF, 8'h00, 8'h00, 1'b1));
		row_typed(uqps_pkg::CH_AMP,
			result_of(uqps_pkg::KIND_PARAM_END, 8'h00, 8'h00, 8'h00, 1'b1));
		// An ampersand closes even an empty parameter.
		row_typed(uqps_pkg::CH_AMP,
			result_of(uqps_pkg::KIND_PARAM_END, 8'h00, 8'h01, 8'h00, 1'b1));
		row_char(uqps_pkg::CH_NUL);
		// Decoding on: plus, lower-case hex, an escape that decodes to zero,
		// an escape broken by the name separator and one broken after a digit.
		row_cfg(ADDR_DECODE, 32'd1);
		row_char(uqps_pkg::CH_PLUS);
		row_char(uqps_pkg::CH_PCT); row_char("4"); row_char("a");
		row_char(uqps_pkg::CH_PCT); row_char("0"); row_char("0");
		row_char(uqps_pkg::CH_PCT); row_char(uqps_pkg::CH_EQ);
		row_char(uqps_pkg::CH_PCT); row_char("4"); row_char(uqps_pkg::CH_AMP);
		row_char(uqps_pkg::CH_PCT); row_char("C");
		// Decoding turned off with an escape half done: it still completes,
		// and the next percent sign is an ordinary byte.
		row_cfg(ADDR_DECODE, 32'd0);
		row_char("1");
		row_char(uqps_pkg::CH_PCT);
		row_char(uqps_pkg::CH_NUL);
		// Limit of one parameter: everything after it is dropped.
		row_cfg(ADDR_MAX_PARAMS, 32'd1);
		row_char("x");
		row_char(uqps_pkg::CH_AMP);
		row_char("y");
		row_typed(uqps_pkg::CH_NUL,
			result_of(uqps_pkg::KIND_QUERY_END, 8'h00, 8'h00, 8'h01, 1'b1));
	endfunction

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Ready generator. A hold request keeps ready low for a long stretch so the
	// result queue fills and the core has to stall its byte input.
	initial begin : result_ready
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Result checker and watchdog. Both look at the falling edge: a result seen
	// with valid and ready high here is the one taken at the next rising edge.
	always @(negedge clk) begin
		uqps_pkg::item_t got;
		uqps_pkg::item_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind        = uqps_pkg::kind_t'(m_axis_tuser);
				got.data_byte   = m_axis_tdata[7:0];
				got.param_index = m_axis_tdata[15:8];
				got.param_total = m_axis_tdata[23:16];
				got.run_last    = m_axis_tlast;
				if (expected_items.size() == 0) begin
					$display("%0t: unexpected result kind %0d data %02h index %0d total %0d",
						$time, got.kind, got.data_byte, got.param_index, got.param_total);
					mismatches++;
				end else begin
					want = expected_items.pop_front();
					if (got.kind != want.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
						mismatches++;
					end
					if (got.data_byte != want.data_byte) begin
						$display("%0t: data_byte expected %02h actual %02h",
							$time, want.data_byte, got.data_byte);
						mismatches++;
					end
					if (got.param_index != want.param_index) begin
						$display("%0t: param_index expected %0d actual %0d",
							$time, want.param_index, got.param_index);
						mismatches++;
					end
					if (got.param_total != want.param_total) begin
						$display("%0t: param_total expected %0d actual %0d",
							$time, want.param_total, got.param_total);
						mismatches++;
					end
					if (got.run_last != want.run_last) begin
						$display("%0t: run_last expected %0b actual %0b",
							$time, want.run_last, got.run_last);
						mismatches++;
					end
				end
			end

			// Any transfer on either stream or the register port counts as progress.
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, WATCHDOG_LIMIT, expected_items.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin : stimulus
		int         sent;
		logic [7:0] max_sel;
		bit         decode_sel;

		build_directed();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: register writes happen only with the core drained.
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				reg_write(dir_rows[i].addr, dir_rows[i].value);
			end else begin
				send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// Random part. Each phase picks register values and an idling pattern;
		// a phase may end mid-query or mid-escape, so settings also change there.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			unique case (p)
				0: begin max_sel = 8'd255; decode_sel = 1'b1; tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin max_sel = 8'd10;  decode_sel = 1'b1; tx_idle_pct = 63; rx_stall_pct = 0;  end
				2: begin max_sel = 8'd2;   decode_sel = 1'b0; tx_idle_pct = 0;  rx_stall_pct = 63; end
				3: begin max_sel = 8'd1;   decode_sel = 1'b1; tx_idle_pct = 32; rx_stall_pct = 32; end
				4: begin
					max_sel      = 8'($urandom_range(1, 255));
					decode_sel   = 1'($urandom_range(1));
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				default: begin max_sel = 8'd3; decode_sel = 1'b1; tx_idle_pct = 32; rx_stall_pct = 32; end
			endcase
			reg_write(ADDR_MAX_PARAMS, {24'd0, max_sel});
			reg_write(ADDR_DECODE, {31'd0, decode_sel});
			// With the sender running flat out, a long hold fills the core.
			if (p == 4) rx_hold_req = 1'b1;

			sent = 0;
			while (sent < CHARS_PER_PHASE) begin
				compose_query();
				foreach (query_chars[i]) begin
					if (sent >= CHARS_PER_PHASE) break;
					send_char(query_chars[i], 1'b0, '0);
					sent++;
				end
			end
		end

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		settle();
		if (mismatches == 0 && expected_items.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/uqps_pkg.sv
rtl/core/uqps_parse.sv
rtl/core/uqps_outq.sv
rtl/core/url_query_param_splitter_core.sv
sim/testbench.sv
